// ===== src/mltm_pkg.sv =====
// Shared types and constants for the MIDI learn trigger matcher.
// Used by every module of the block; depends on nothing else.

package mltm_pkg;

   localparam int SLOTS_DEF = 8;
   localparam int KEY_W     = 16;
   localparam int QDEPTH    = 2;

   // Raw command codes on the request channel.
   localparam logic [2:0] CMD_MIDI  = 3'd0;
   localparam logic [2:0] CMD_LEARN = 3'd1;
   localparam logic [2:0] CMD_CLEAR = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_MUTE  = 3'd4;

   // Event codes on the response channel.
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_LEARNED = 3'd1;
   localparam logic [2:0] EV_STOP    = 3'd2;
   localparam logic [2:0] EV_GO      = 3'd3;
   localparam logic [2:0] EV_FULL    = 3'd4;

   // Learn state codes.
   localparam logic [1:0] LS_STOP = 2'd0;
   localparam logic [1:0] LS_GO   = 2'd1;
   localparam logic [1:0] LS_NOT  = 2'd2;

   typedef enum logic [2:0] {
      OP_MSG,
      OP_LEARN,
      OP_CLEAR,
      OP_READ,
      OP_MUTE,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key;
      logic             table_sel;
      logic [2:0]       slot_index;
      logic             flag_value;
   } item_type;

endpackage

// ===== src/mltm_front.sv =====
// Front end of the trigger matcher: accepts request transactions, decodes the
// command and forms the queue entry. Depends on mltm_pkg.

module mltm_front (
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_cmd,
   input  logic [7:0]          req_status_byte,
   input  logic [7:0]          req_data_byte,
   input  logic                req_table_sel,
   input  logic [2:0]          req_slot_index,
   input  logic                req_flag_value,
   input  logic                q_full,
   output logic                q_push,
   output mltm_pkg::item_type  q_item
);

   mltm_pkg::op_type op;

   always_comb begin
      unique case (req_cmd)
         mltm_pkg::CMD_MIDI:  op = mltm_pkg::OP_MSG;
         mltm_pkg::CMD_LEARN: op = mltm_pkg::OP_LEARN;
         mltm_pkg::CMD_CLEAR: op = mltm_pkg::OP_CLEAR;
         mltm_pkg::CMD_READ:  op = mltm_pkg::OP_READ;
         mltm_pkg::CMD_MUTE:  op = mltm_pkg::OP_MUTE;
         default:             op = mltm_pkg::OP_NOP;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.op         = op;
      q_item.key        = {req_status_byte, req_data_byte};
      q_item.table_sel  = req_table_sel;
      q_item.slot_index = req_slot_index;
      q_item.flag_value = req_flag_value;
   end

endmodule

// ===== src/mltm_fifo.sv =====
// Short queue between the front end and the table sequencer.
// Depends on mltm_pkg for the entry type and depth.

module mltm_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mltm_pkg::item_type push_item,
   input  logic               pop,
   output mltm_pkg::item_type head,
   output logic               empty,
   output logic               full
);

   localparam int PW = (mltm_pkg::QDEPTH > 1) ? $clog2(mltm_pkg::QDEPTH) : 1;
   localparam int CW = $clog2(mltm_pkg::QDEPTH + 1);

   mltm_pkg::item_type q_ff [mltm_pkg::QDEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(mltm_pkg::QDEPTH));
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(mltm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(mltm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/mltm_back.sv =====
// Table sequencer of the trigger matcher: holds both key tables, the learn
// state and the muted flag, scans the tables slot by slot and registers the
// response. Depends on mltm_pkg.

module mltm_back #(
   parameter int SLOTS = mltm_pkg::SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  mltm_pkg::item_type         q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_muted,
   output logic [1:0]                 rsp_learn_mode,
   output logic [2:0]                 rsp_event_res,
   output logic [mltm_pkg::KEY_W-1:0] rsp_slot_key,
   output logic                       rsp_slot_valid
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KW = mltm_pkg::KEY_W;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_SCAN    = 6'b000010,
      S_TAIL    = 6'b000100,
      S_RESOLVE = 6'b001000,
      S_RDATA   = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [KW-1:0] stop_mem [SLOTS];
   logic [KW-1:0] go_mem   [SLOTS];
   logic [KW-1:0] rd_stop_ff, rd_go_ff;
   logic [AW-1:0] rd_addr;
   logic          stop_we, go_we;

   logic [SLOTS-1:0] stop_vld_ff, stop_vld_in;
   logic [SLOTS-1:0] go_vld_ff, go_vld_in;
   logic [1:0]       ls_ff, ls_in;
   logic             muted_ff, muted_in;

   mltm_pkg::item_type cur_ff, cur_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic          found_ff, found_in;
   logic [AW-1:0] first_ff, first_in;
   logic          stop_hit_ff, stop_hit_in;
   logic          go_hit_ff, go_hit_in;
   logic [2:0]    ev_ff, ev_in;
   logic [KW-1:0] skey_ff, skey_in;
   logic          svld_ff, svld_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_muted_ff, rsp_muted_in;
   logic [1:0]    rsp_ls_ff, rsp_ls_in;
   logic [2:0]    rsp_ev_ff, rsp_ev_in;
   logic [KW-1:0] rsp_key_ff, rsp_key_in;
   logic          rsp_svld_ff, rsp_svld_in;

   logic          learning;
   logic          in_range;
   logic [AW-1:0] slot_addr;
   logic          slot_hit;

   assign learning  = (ls_ff == mltm_pkg::LS_STOP) || (ls_ff == mltm_pkg::LS_GO);
   assign slot_addr = AW'(cur_ff.slot_index);
   assign in_range  = int'(cur_ff.slot_index) < SLOTS;
   assign slot_hit  = in_range &&
                      (cur_ff.table_sel ? go_vld_ff[slot_addr] : stop_vld_ff[slot_addr]);

   always_comb begin
      state_in     = state_ff;
      stop_vld_in  = stop_vld_ff;
      go_vld_in    = go_vld_ff;
      ls_in        = ls_ff;
      muted_in     = muted_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      cmp_idx_in   = cnt_ff;
      cmp_vld_in   = (state_ff == S_SCAN);
      found_in     = found_ff;
      first_in     = first_ff;
      stop_hit_in  = stop_hit_ff;
      go_hit_in    = go_hit_ff;
      ev_in        = ev_ff;
      skey_in      = skey_ff;
      svld_in      = svld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_muted_in = rsp_muted_ff;
      rsp_ls_in    = rsp_ls_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_svld_in  = rsp_svld_ff;
      q_pop        = 1'b0;
      rd_addr      = cnt_ff;
      stop_we      = 1'b0;
      go_we        = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Compare stage: works on the key read for the slot issued last cycle.
      if (cmp_vld_ff) begin
         if (learning) begin
            if (ls_ff == mltm_pkg::LS_STOP) begin
               if (go_vld_ff[cmp_idx_ff] && rd_go_ff == cur_ff.key) begin
                  go_vld_in[cmp_idx_ff] = 1'b0;
               end
               if (!found_ff && !stop_vld_ff[cmp_idx_ff]) begin
                  found_in = 1'b1;
                  first_in = cmp_idx_ff;
               end
            end else begin
               if (stop_vld_ff[cmp_idx_ff] && rd_stop_ff == cur_ff.key) begin
                  stop_vld_in[cmp_idx_ff] = 1'b0;
               end
               if (!found_ff && !go_vld_ff[cmp_idx_ff]) begin
                  found_in = 1'b1;
                  first_in = cmp_idx_ff;
               end
            end
         end else begin
            stop_hit_in = stop_hit_ff ||
                          (stop_vld_ff[cmp_idx_ff] && rd_stop_ff == cur_ff.key);
            go_hit_in   = go_hit_ff || (go_vld_ff[cmp_idx_ff] && rd_go_ff == cur_ff.key);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               cur_in      = q_head;
               cnt_in      = '0;
               found_in    = 1'b0;
               stop_hit_in = 1'b0;
               go_hit_in   = 1'b0;
               ev_in       = mltm_pkg::EV_NONE;
               skey_in     = '0;
               svld_in     = 1'b0;
               state_in    = S_DONE;
               unique case (q_head.op)
                  mltm_pkg::OP_MSG: begin
                     state_in = S_SCAN;
                  end
                  mltm_pkg::OP_READ: begin
                     rd_addr  = AW'(q_head.slot_index);
                     state_in = S_RDATA;
                  end
                  mltm_pkg::OP_LEARN: begin
                     ls_in = q_head.flag_value ? {1'b0, q_head.table_sel}
                                               : mltm_pkg::LS_NOT;
                  end
                  mltm_pkg::OP_CLEAR: begin
                     if (q_head.table_sel) begin
                        go_vld_in = '0;
                     end else begin
                        stop_vld_in = '0;
                     end
                  end
                  mltm_pkg::OP_MUTE: begin
                     muted_in = q_head.flag_value;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (cnt_ff == AW'(SLOTS - 1)) begin
               state_in = S_TAIL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_TAIL: begin
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            state_in = S_DONE;
            if (learning) begin
               if (found_ff) begin
                  if (ls_ff == mltm_pkg::LS_STOP) begin
                     stop_we               = 1'b1;
                     stop_vld_in[first_ff] = 1'b1;
                  end else begin
                     go_we               = 1'b1;
                     go_vld_in[first_ff] = 1'b1;
                  end
                  if (first_ff == AW'(SLOTS - 1)) begin
                     ls_in = mltm_pkg::LS_NOT;
                  end
                  ev_in = mltm_pkg::EV_LEARNED;
               end else begin
                  ev_in = mltm_pkg::EV_FULL;
               end
            end else if (stop_hit_ff) begin
               muted_in = 1'b1;
               ev_in    = mltm_pkg::EV_STOP;
            end else if (go_hit_ff) begin
               muted_in = 1'b0;
               ev_in    = mltm_pkg::EV_GO;
            end else begin
               ev_in = mltm_pkg::EV_NONE;
            end
         end
         S_RDATA: begin
            svld_in  = slot_hit;
            skey_in  = slot_hit ? (cur_ff.table_sel ? rd_go_ff : rd_stop_ff) : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_muted_in = muted_ff;
               rsp_ls_in    = ls_ff;
               rsp_ev_in    = ev_ff;
               rsp_key_in   = skey_ff;
               rsp_svld_in  = svld_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stop_vld_ff  <= '0;
         go_vld_ff    <= '0;
         ls_ff        <= mltm_pkg::LS_NOT;
         muted_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stop_vld_ff  <= stop_vld_in;
         go_vld_ff    <= go_vld_in;
         ls_ff        <= ls_in;
         muted_ff     <= muted_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      found_ff    <= found_in;
      first_ff    <= first_in;
      stop_hit_ff <= stop_hit_in;
      go_hit_ff   <= go_hit_in;
      ev_ff       <= ev_in;
      skey_ff     <= skey_in;
      svld_ff     <= svld_in;
      rsp_muted_ff <= rsp_muted_in;
      rsp_ls_ff    <= rsp_ls_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_svld_ff  <= rsp_svld_in;
   end

   // Key tables: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (stop_we) begin
         stop_mem[first_ff] <= cur_ff.key;
      end
      rd_stop_ff <= stop_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (go_we) begin
         go_mem[first_ff] <= cur_ff.key;
      end
      rd_go_ff <= go_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_muted      = rsp_muted_ff;
   assign rsp_learn_mode = rsp_ls_ff;
   assign rsp_event_res  = rsp_ev_ff;
   assign rsp_slot_key   = rsp_key_ff;
   assign rsp_slot_valid = rsp_svld_ff;

endmodule

// ===== src/midi_learn_trigger_matcher.sv =====
// Top level of the MIDI learn trigger matcher: front end, queue and table
// sequencer. Depends on mltm_pkg, mltm_front, mltm_fifo and mltm_back.
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_stall   cmd, status_byte, data_byte,
//                                               table_sel, slot_index, flag_value
//   rsp_      out         rsp_valid/rsp_stall   muted, learn_mode, event_res,
//                                               slot_key, slot_valid
//
// A MIDI message steps through S_SCAN, S_TAIL, S_RESOLVE and S_DONE: the
// sequencer reads one slot of both key tables per cycle through their registered
// read ports. A slot read steps through S_RDATA and S_DONE, and every other
// command goes straight to S_DONE, the state that loads the response register.
// Reset clears the valid bits, learn state and muted flag.
// A stalled response holds the sequencer; the two-entry queue keeps taking
// requests until it is full, then req_stall rises.

module midi_learn_trigger_matcher #(
   parameter int SLOTS = mltm_pkg::SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_status_byte,
   input  logic [7:0]  req_data_byte,
   input  logic        req_table_sel,
   input  logic [2:0]  req_slot_index,
   input  logic        req_flag_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_muted,
   output logic [1:0]  rsp_learn_mode,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_slot_key,
   output logic        rsp_slot_valid
);

   mltm_pkg::item_type push_item;
   mltm_pkg::item_type head;
   logic               push, pop, empty, full;

   mltm_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_status_byte (req_status_byte),
      .req_data_byte   (req_data_byte),
      .req_table_sel   (req_table_sel),
      .req_slot_index  (req_slot_index),
      .req_flag_value  (req_flag_value),
      .q_full          (full),
      .q_push          (push),
      .q_item          (push_item)
   );

   mltm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   mltm_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (empty),
      .q_head         (head),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_muted      (rsp_muted),
      .rsp_learn_mode (rsp_learn_mode),
      .rsp_event_res  (rsp_event_res),
      .rsp_slot_key   (rsp_slot_key),
      .rsp_slot_valid (rsp_slot_valid)
   );

endmodule
